@@ hw/rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge
`define ATP_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// implication checked at every edge
`define ATP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/atp_pkg.sv @@
`timescale 1ns / 1ps
package atp_pkg;

	localparam int SAMPLE_WIDTH_DEF     = 16;
	localparam int HALF_TURN_COUNTS_DEF = 8192;

	// datapath: samples scaled to 2^40 full scale, with headroom for cordic gain
	localparam int SCALE_BITS  = 40;
	localparam int DP_W        = 44;
	// angle accumulator, half a turn is 2^25
	localparam int ANGLE_FRAC  = 25;
	localparam int ACC_W       = 28;
	localparam int STEPS       = 25;
	localparam int OUT_W       = 14;
	localparam int INV_GAIN_Q20 = 636751;

	typedef logic signed [DP_W-1:0]  dp_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		dp_t  x;
		dp_t  y;
		acc_t a;
	} cord_t;

	// atan(2^-i)/pi * 2^25, rounded
	function automatic acc_t atan_tab(input int i);
		unique case (i)
			0:  atan_tab = ACC_W'(8388608);
			1:  atan_tab = ACC_W'(4952084);
			2:  atan_tab = ACC_W'(2616545);
			3:  atan_tab = ACC_W'(1328199);
			4:  atan_tab = ACC_W'(666677);
			5:  atan_tab = ACC_W'(333664);
			6:  atan_tab = ACC_W'(166872);
			7:  atan_tab = ACC_W'(83441);
			8:  atan_tab = ACC_W'(41721);
			9:  atan_tab = ACC_W'(20861);
			10: atan_tab = ACC_W'(10430);
			11: atan_tab = ACC_W'(5215);
			12: atan_tab = ACC_W'(2608);
			13: atan_tab = ACC_W'(1304);
			14: atan_tab = ACC_W'(652);
			15: atan_tab = ACC_W'(326);
			16: atan_tab = ACC_W'(163);
			17: atan_tab = ACC_W'(81);
			18: atan_tab = ACC_W'(41);
			19: atan_tab = ACC_W'(20);
			20: atan_tab = ACC_W'(10);
			21: atan_tab = ACC_W'(5);
			22: atan_tab = ACC_W'(3);
			default: atan_tab = ACC_W'(1);
		endcase
	endfunction

	// quadrant pre-rotation by +-90 degrees into the right half plane
	function automatic cord_t pre_rot(input dp_t x, input dp_t y);
		cord_t r;
		r.x = x;
		r.y = y;
		r.a = '0;
		if (x < 0) begin
			if (y >= 0) begin
				r.x = y;
				r.y = -x;
				r.a = acc_t'(1) <<< (ANGLE_FRAC - 1);
			end else begin
				r.x = -y;
				r.y = x;
				r.a = -(acc_t'(1) <<< (ANGLE_FRAC - 1));
			end
		end
		return r;
	endfunction

	// one vectoring micro-rotation, shifts round toward minus infinity
	function automatic cord_t cord_step(input cord_t c, input int i);
		cord_t r;
		dp_t   dx;
		dp_t   dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		if (c.y >= 0) begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.a = c.a + atan_tab(i);
		end else begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.a = c.a - atan_tab(i);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/atp_in_if.sv @@
`timescale 1ns / 1ps
interface atp_in_if #(
	parameter int SAMPLE_WIDTH = atp_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] accel_x;
	logic signed [SAMPLE_WIDTH-1:0] accel_y;
	logic signed [SAMPLE_WIDTH-1:0] accel_z;

	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

@@ hw/rtl/atp_out_if.sv @@
`timescale 1ns / 1ps
interface atp_out_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] pitch_angle;
	logic signed [13:0] roll_angle;

	modport source (output valid, pitch_angle, roll_angle, input ready);
	modport sink (input valid, pitch_angle, roll_angle, output ready);
endinterface

@@ hw/rtl/accel_tilt_pitch_roll.sv @@
`timescale 1ns / 1ps
// channel   dir  word
// sample    in   accel_x, accel_y, accel_z (SAMPLE_WIDTH bits, signed)
// tilt      out  pitch_angle, roll_angle (14 bits, signed, counts)
//
// one sample per clock, unless a stalled result holds the pipeline
// the pipeline is two 25-stage cordic chains (roll, then pitch on the roll magnitude)
// plus pre-rotation, gain multiply and count scaling stages
// arst_n clears the valid bits only; the datapath carries no reset
// a stalled result freezes the whole pipeline, sample.ready drops with it
module accel_tilt_pitch_roll #(
	parameter int SAMPLE_WIDTH     = atp_pkg::SAMPLE_WIDTH_DEF,
	parameter int HALF_TURN_COUNTS = atp_pkg::HALF_TURN_COUNTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	atp_in_if.sink    sample,
	atp_out_if.source tilt
);
	import atp_pkg::*;
	`include "assert_macros.svh"

	localparam int HTC_W = $clog2(HALF_TURN_COUNTS) + 2;
	localparam int PW    = ACC_W + HTC_W;
	localparam int MW    = 64;

	typedef logic signed [PW-1:0] prod_t;

	// angle product to counts, halves away from zero, clipped
	function automatic logic signed [OUT_W-1:0] to_counts(input prod_t p);
		prod_t m;
		prod_t c;
		m = (p < 0) ? -p : p;
		c = (m + (prod_t'(1) <<< (ANGLE_FRAC - 1))) >>> ANGLE_FRAC;
		c = (p < 0) ? -c : c;
		if (c > prod_t'(HALF_TURN_COUNTS - 1))
			c = prod_t'(HALF_TURN_COUNTS - 1);
		if (c < -prod_t'(HALF_TURN_COUNTS))
			c = -prod_t'(HALF_TURN_COUNTS);
		return c[OUT_W-1:0];
	endfunction

	function automatic dp_t load(input logic signed [SAMPLE_WIDTH-1:0] s);
		return dp_t'(s) <<< (SCALE_BITS - SAMPLE_WIDTH);
	endfunction

	logic en;
	assign en = !tilt.valid || tilt.ready;
	assign sample.ready = en;

	// roll cordic chain, x carries along
	cord_t rc_s [0:STEPS];
	logic  rv_s [0:STEPS];
	logic  rz_s [0:STEPS];
	dp_t   rax_s [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s[0] <= 1'b0;
		else if (en) rv_s[0] <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rc_s[0]  <= pre_rot(load(sample.accel_z), load(sample.accel_y));
			rz_s[0]  <= (sample.accel_z == '0) && (sample.accel_y == '0);
			rax_s[0] <= load(sample.accel_x);
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_roll
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[i+1] <= 1'b0;
			else if (en) rv_s[i+1] <= rv_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rc_s[i+1]  <= cord_step(rc_s[i], i);
				rz_s[i+1]  <= rz_s[i];
				rax_s[i+1] <= rax_s[i];
			end
		end
	end

	// gain partial products and roll angle scaling
	dp_t                  kmag;
	logic [40:0]          glo_s1;
	logic [41:0]          ghi_s1;
	prod_t                rp_s1;
	dp_t                  ax_s1;
	logic                 v_s1;

	assign kmag = (rz_s[STEPS] || rc_s[STEPS].x < 0) ? '0 : rc_s[STEPS].x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= rv_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			glo_s1 <= 41'(kmag[20:0]) * 41'(INV_GAIN_Q20);
			ghi_s1 <= 42'(kmag[DP_W-2:21]) * 42'(INV_GAIN_Q20);
			rp_s1  <= (rz_s[STEPS] ? prod_t'(0) : prod_t'(rc_s[STEPS].a))
				* prod_t'(HALF_TURN_COUNTS);
			ax_s1  <= rax_s[STEPS];
		end
	end

	// combine partial products, round half up, and finish roll counts
	logic [MW-1:0]           gsum;
	dp_t                     r_s2;
	dp_t                     ax_s2;
	logic signed [OUT_W-1:0] roll_s2;
	logic                    v_s2;

	assign gsum = (MW'(ghi_s1) << 21) + MW'(glo_s1) + (MW'(1) << 19);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2    <= dp_t'(gsum[DP_W+19:20]);
			ax_s2   <= ax_s1;
			roll_s2 <= to_counts(rp_s1);
		end
	end

	// pitch cordic chain, roll counts carry along
	cord_t                   pc_s [0:STEPS];
	logic                    pv_s [0:STEPS];
	logic                    pz_s [0:STEPS];
	logic signed [OUT_W-1:0] proll_s [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s[0] <= 1'b0;
		else if (en) pv_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s[0]    <= pre_rot(r_s2, ax_s2);
			pz_s[0]    <= (r_s2 == '0) && (ax_s2 == '0);
			proll_s[0] <= roll_s2;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_pitch
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) pv_s[i+1] <= 1'b0;
			else if (en) pv_s[i+1] <= pv_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pc_s[i+1]    <= cord_step(pc_s[i], i);
				pz_s[i+1]    <= pz_s[i];
				proll_s[i+1] <= proll_s[i];
			end
		end
	end

	// pitch angle scaling
	prod_t                   pp_s3;
	logic signed [OUT_W-1:0] roll_s3;
	logic                    v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= pv_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s3   <= (pz_s[STEPS] ? prod_t'(0) : prod_t'(pc_s[STEPS].a))
				* prod_t'(HALF_TURN_COUNTS);
			roll_s3 <= proll_s[STEPS];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tilt.valid <= 1'b0;
		else if (en) tilt.valid <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tilt.pitch_angle <= to_counts(pp_s3);
			tilt.roll_angle  <= roll_s3;
		end
	end

	// roll magnitude feeding the gain stage is never negative
	`ATP_ASSERT_IMP(a_mag_pos, rv_s[STEPS] && !rz_s[STEPS], rc_s[STEPS].x >= 0, "negative roll magnitude")
	// pitch operand after gain is never negative
	`ATP_ASSERT_IMP(a_r_pos, v_s2, r_s2 >= 0, "negative pitch operand")
	// zero pitch operands carry a zero angle through scaling
	`ATP_ASSERT_IMP(a_pz_zero, en && pv_s[STEPS] && pz_s[STEPS], ##1 pp_s3 == '0, "zero pitch not zero")
	// pitch stays within a quarter turn each way
	`ATP_ASSERT_IMP(a_pitch_rng, tilt.valid, tilt.pitch_angle <= 14'sd4096 && tilt.pitch_angle >= -14'sd4096, "pitch out of range")

endmodule
